### src/dhb_pkg.sv
// Shared types, constants and helper functions for the DTS core header bitrate block.
// Used by the parser front end, the job queue, the bitrate back end and the top level.
// Depends on nothing.
package dhb_pkg;

	localparam int unsigned NBLK_W    = 7;
	localparam int unsigned FSIZE_W   = 14;
	localparam int unsigned RATE_W    = 18;
	localparam int unsigned Q8_W      = 38;
	localparam int unsigned PROD_W    = 32;
	localparam int unsigned Q8_SHIFT  = 6;
	localparam int unsigned DIVISOR_W = NBLK_W + 1;
	localparam int unsigned DIV_CNT_W = 6;
	localparam int unsigned HDR_W     = 64;
	localparam int unsigned JOBQ_DEPTH = 2;
	localparam int unsigned JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
	localparam int unsigned JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

	localparam logic [23:0] SYNC_BE_HEAD = 24'h7FFE80;
	localparam logic [7:0]  SYNC_BE_TAIL = 8'h01;
	localparam logic [23:0] SYNC_SW_HEAD = 24'hFE7F01;
	localparam logic [7:0]  SYNC_SW_TAIL = 8'h80;
	localparam logic [3:0]  HDR_BYTES    = 4'd8;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_COLLECT = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SYNC  = 2'd1,
		ST_SHORT    = 2'd2,
		ST_BAD_RATE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_MUL  = 2'd1,
		BK_DIV  = 2'd2,
		BK_FIN  = 2'd3
	} back_state_t;

	typedef struct packed {
		status_t              status;
		logic                 swapped;
		logic [NBLK_W-1:0]    nblks;
		logic [FSIZE_W-1:0]   fsize;
		logic [RATE_W-1:0]    rate;
	} job_t;

	function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
		logic [RATE_W-1:0] r;
		begin
			unique case (idx)
				4'd1:    r = 18'd8000;
				4'd2:    r = 18'd16000;
				4'd3:    r = 18'd32000;
				4'd6:    r = 18'd11025;
				4'd7:    r = 18'd22050;
				4'd8:    r = 18'd44100;
				4'd11:   r = 18'd12000;
				4'd12:   r = 18'd24000;
				4'd13:   r = 18'd48000;
				4'd14:   r = 18'd96000;
				4'd15:   r = 18'd192000;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [HDR_W-1:0] swap_pairs(input logic [HDR_W-1:0] v);
		logic [HDR_W-1:0] r;
		begin
			for (int i = 0; i < HDR_W / 16; i++) begin
				r[16*i +: 8]     = v[16*i + 8 +: 8];
				r[16*i + 8 +: 8] = v[16*i +: 8];
			end
			return r;
		end
	endfunction

endpackage

### src/dhb_front.sv
// Front end: hunts for the core sync word, collects the header bytes and
// classifies each buffer into a job for the back end. Depends on dhb_pkg.
module dhb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              job_valid,
	output dhb_pkg::job_t     job
);

	logic [23:0]                  window_q, window_n, window_d;
	dhb_pkg::phase_t              phase_q, phase_n, phase_d;
	logic                         swap_q, swap_n, swap_d;
	logic [3:0]                   count_q, count_n, count_d;
	logic [dhb_pkg::HDR_W-1:0]    hdr_q, hdr_n;
	logic [dhb_pkg::HDR_W-1:0]    hdr_view;
	logic [dhb_pkg::RATE_W-1:0]   rate;

	always_comb begin
		window_n = window_q;
		phase_n  = phase_q;
		swap_n   = swap_q;
		count_n  = count_q;
		hdr_n    = hdr_q;
		if (accept) begin
			unique case (phase_q)
				dhb_pkg::PH_HUNT: begin
					// The sync byte itself is not shifted into the window.
					if (window_q == dhb_pkg::SYNC_BE_HEAD && data_byte == dhb_pkg::SYNC_BE_TAIL) begin
						phase_n = dhb_pkg::PH_COLLECT;
						swap_n  = 1'b0;
						count_n = '0;
					end else if (window_q == dhb_pkg::SYNC_SW_HEAD &&
							data_byte == dhb_pkg::SYNC_SW_TAIL) begin
						phase_n = dhb_pkg::PH_COLLECT;
						swap_n  = 1'b1;
						count_n = '0;
					end else begin
						window_n = {window_q[15:0], data_byte};
					end
				end
				dhb_pkg::PH_COLLECT: begin
					hdr_n   = {hdr_q[dhb_pkg::HDR_W-9:0], data_byte};
					count_n = count_q + 4'd1;
					if (count_n >= dhb_pkg::HDR_BYTES) begin
						phase_n = dhb_pkg::PH_DONE;
					end
				end
				dhb_pkg::PH_DONE: begin
				end
				default: begin
					phase_n = dhb_pkg::PH_HUNT;
				end
			endcase
		end

		// The marked byte closes the buffer and returns the parser to hunting.
		window_d = window_n;
		phase_d  = phase_n;
		swap_d   = swap_n;
		count_d  = count_n;
		if (accept && last_byte) begin
			window_d = '0;
			phase_d  = dhb_pkg::PH_HUNT;
			swap_d   = 1'b0;
			count_d  = '0;
		end
	end

	assign hdr_view = swap_n ? dhb_pkg::swap_pairs(hdr_n) : hdr_n;
	assign rate     = dhb_pkg::rate_lookup(hdr_view[29:26]);

	always_comb begin
		job_valid   = accept && last_byte;
		job.nblks   = hdr_view[56:50];
		job.fsize   = hdr_view[49:36];
		job.rate    = rate;
		job.swapped = swap_n;
		if (phase_n == dhb_pkg::PH_HUNT) begin
			job.status  = dhb_pkg::ST_NO_SYNC;
			job.swapped = 1'b0;
		end else if (phase_n != dhb_pkg::PH_DONE) begin
			job.status = dhb_pkg::ST_SHORT;
		end else if (rate == '0) begin
			job.status = dhb_pkg::ST_BAD_RATE;
		end else begin
			job.status = dhb_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			phase_q  <= dhb_pkg::PH_HUNT;
			swap_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			window_q <= window_d;
			phase_q  <= phase_d;
			swap_q   <= swap_d;
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		hdr_q <= hdr_n;
	end

endmodule

### src/dhb_job_fifo.sv
// Short queue of classified jobs between the parser front end and the
// bitrate back end. Depends on dhb_pkg.
module dhb_job_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  dhb_pkg::job_t     wr_data,
	output logic              full,
	input  logic              rd_en,
	output dhb_pkg::job_t     rd_data,
	output logic              empty
);

	dhb_pkg::job_t                       mem_q [dhb_pkg::JOBQ_DEPTH];
	logic [dhb_pkg::JOBQ_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [dhb_pkg::JOBQ_CNT_W-1:0]      count_q;
	logic                                do_wr, do_rd;

	assign full    = (count_q == dhb_pkg::JOBQ_CNT_W'(dhb_pkg::JOBQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == dhb_pkg::JOBQ_PTR_W'(dhb_pkg::JOBQ_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == dhb_pkg::JOBQ_PTR_W'(dhb_pkg::JOBQ_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### src/dhb_back.sv
// Back end: multiplies frame size by sample rate, divides by the block count
// one quotient bit per cycle and holds the result for the consumer. Depends on dhb_pkg.
module dhb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_empty,
	input  dhb_pkg::job_t              job_head,
	output logic                       job_pop,
	output logic [1:0]                 status,
	output logic [dhb_pkg::Q8_W-1:0]   bitrate_q8,
	output logic                       swapped_order,
	output logic                       empty,
	input  logic                       pop
);

	dhb_pkg::back_state_t               state_q, state_d;
	dhb_pkg::job_t                      job_q;
	logic [dhb_pkg::Q8_W-1:0]           quo_q, quo_d;
	logic [dhb_pkg::NBLK_W-1:0]         rem_q, rem_d;
	logic [dhb_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;
	logic                               out_valid_q;
	dhb_pkg::status_t                   out_status_q;
	logic [dhb_pkg::Q8_W-1:0]           out_q8_q;
	logic                               out_swapped_q;

	logic [dhb_pkg::FSIZE_W:0]          fsize_p1;
	logic [dhb_pkg::PROD_W-1:0]         prod_full;
	logic [dhb_pkg::DIVISOR_W-1:0]      divisor;
	logic [dhb_pkg::DIVISOR_W-1:0]      rem_sh;
	logic [dhb_pkg::DIVISOR_W-1:0]      rem_sub;
	logic                               q_bit;
	logic                               load_out;

	assign fsize_p1  = {1'b0, job_q.fsize} + 1'b1;
	// The largest product, 16384 * 192000, still fits in 32 bits.
	assign prod_full = dhb_pkg::PROD_W'(fsize_p1) * dhb_pkg::PROD_W'(job_q.rate);
	assign divisor   = {1'b0, job_q.nblks} + 1'b1;

	// Restoring division: the remainder stays below the divisor, which is at most 128.
	assign rem_sh  = {rem_q, quo_q[dhb_pkg::Q8_W-1]};
	assign q_bit   = (rem_sh >= divisor);
	assign rem_sub = rem_sh - divisor;

	always_comb begin
		state_d  = state_q;
		quo_d    = quo_q;
		rem_d    = rem_q;
		cnt_d    = cnt_q;
		job_pop  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			dhb_pkg::BK_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = (job_head.status == dhb_pkg::ST_OK) ? dhb_pkg::BK_MUL
						: dhb_pkg::BK_FIN;
				end
			end
			dhb_pkg::BK_MUL: begin
				quo_d   = {prod_full, dhb_pkg::Q8_SHIFT'(0)};
				rem_d   = '0;
				cnt_d   = '0;
				state_d = dhb_pkg::BK_DIV;
			end
			dhb_pkg::BK_DIV: begin
				rem_d = q_bit ? rem_sub[dhb_pkg::NBLK_W-1:0] : rem_sh[dhb_pkg::NBLK_W-1:0];
				quo_d = {quo_q[dhb_pkg::Q8_W-2:0], q_bit};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == dhb_pkg::DIV_CNT_W'(dhb_pkg::Q8_W - 1)) begin
					state_d = dhb_pkg::BK_FIN;
				end
			end
			dhb_pkg::BK_FIN: begin
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d  = dhb_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = dhb_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dhb_pkg::BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		quo_q <= quo_d;
		rem_q <= rem_d;
		if (job_pop) begin
			job_q <= job_head;
		end
		if (load_out) begin
			out_status_q  <= job_q.status;
			out_q8_q      <= (job_q.status == dhb_pkg::ST_OK) ? quo_q : '0;
			out_swapped_q <= job_q.swapped;
		end
	end

	assign status        = out_status_q;
	assign bitrate_q8    = out_q8_q;
	assign swapped_order = out_swapped_q;
	assign empty         = !out_valid_q;

endmodule

### src/dts_core_header_bitrate.sv
// Top level of the DTS core header bitrate block: parser front end, job queue
// and bitrate back end. Depends on dhb_pkg, dhb_front, dhb_job_fifo and dhb_back.
//
// Usage: the input side is a queue write port. A byte of the buffer is taken
// at each clock edge where push is high and full is low; last_byte marks the
// final byte of a buffer. Every buffer yields exactly one result, read like a
// queue: while empty is low the oldest result sits on status, bitrate_q8 and
// swapped_order, and it leaves at an edge where pop is high.
// Flow: the parser takes one byte per cycle while full is low. Each finished buffer
// becomes a job in a two-entry queue. The back end works on one job at a time: it
// takes the job and, for a valid header, runs a multiply state, a restoring divider
// that produces one of the 38 quotient bits per cycle, and a state that loads the
// output register; a job without a valid header goes straight to that load state,
// which waits while an unpopped result still holds the output register.
// full rises only when the job queue holds two jobs; a stalled consumer first
// fills the output register, then the queue, and then holds off the input.
// An asynchronous reset returns the parser to sync hunting and drops all jobs
// and any waiting result.
module dts_core_header_bitrate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [1:0]                  status,
	output logic [dhb_pkg::Q8_W-1:0]    bitrate_q8,
	output logic                        swapped_order
);

	logic              accept;
	logic              job_valid;
	dhb_pkg::job_t     job_in;
	dhb_pkg::job_t     job_head;
	logic              job_full;
	logic              job_empty;
	logic              job_pop;

	assign full   = job_full;
	assign accept = push && !job_full;

	dhb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.job_valid (job_valid),
		.job       (job_in)
	);

	dhb_job_fifo u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_valid),
		.wr_data (job_in),
		.full    (job_full),
		.rd_en   (job_pop),
		.rd_data (job_head),
		.empty   (job_empty)
	);

	dhb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_empty     (job_empty),
		.job_head      (job_head),
		.job_pop       (job_pop),
		.status        (status),
		.bitrate_q8    (bitrate_q8),
		.swapped_order (swapped_order),
		.empty         (empty),
		.pop           (pop)
	);

endmodule

### tb/tb_dts_core_header_bitrate.sv
// Self-checking testbench for dts_core_header_bitrate: byte buffers with DTS core headers
// are pushed in, every result is checked against an in-bench header parser and bitrate model.
// Depends on dhb_pkg and the dts_core_header_bitrate RTL.
module tb_dts_core_header_bitrate;

	typedef struct packed {
		dhb_pkg::status_t          st;
		logic [dhb_pkg::Q8_W-1:0]  q8;
		logic                      sw;
	} bitrate_res_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
		logic       hold;
		logic [1:0] phase;
	} byte_item_t;

	localparam int unsigned WATCHDOG_LIMIT = 4000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic [7:0]                 data_byte = 8'h00;
	logic                       last_byte = 1'b0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic [1:0]                 status;
	logic [dhb_pkg::Q8_W-1:0]   bitrate_q8;
	logic                       swapped_order;

	byte_item_t    item_q[$];
	bitrate_res_t  result_q[$];
	int            n_queued = 0;
	logic [1:0]    fill_phase = 2'd0;
	logic [1:0]    cur_phase = 2'd0;
	logic          in_fire = 1'b0;
	int            fail_cnt = 0;
	int            idle_cyc = 0;

	// Shadow state of the header parser.
	logic [23:0]        hunt_win = '0;
	dhb_pkg::phase_t    fr_phase = dhb_pkg::PH_HUNT;
	logic               fr_swap = 1'b0;
	logic [3:0]         hdr_cnt = '0;
	logic [63:0]        hdr_sr = '0;

	dts_core_header_bitrate dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.bitrate_q8    (bitrate_q8),
		.swapped_order (swapped_order)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned sfreq_hz(input logic [3:0] idx);
		int unsigned hz;
		case (idx)
			4'd1:    hz = 8000;
			4'd2:    hz = 16000;
			4'd3:    hz = 32000;
			4'd6:    hz = 11025;
			4'd7:    hz = 22050;
			4'd8:    hz = 44100;
			4'd11:   hz = 12000;
			4'd12:   hz = 24000;
			4'd13:   hz = 48000;
			4'd14:   hz = 96000;
			4'd15:   hz = 192000;
			default: hz = 0;
		endcase
		return hz;
	endfunction

	function automatic logic [63:0] swap_byte_pairs(input logic [63:0] v);
		logic [63:0] s;
		for (int w = 0; w < 4; w++) begin
			s[16*w +: 8]     = v[16*w + 8 +: 8];
			s[16*w + 8 +: 8] = v[16*w +: 8];
		end
		return s;
	endfunction

	function automatic int idle_pct(input logic [1:0] ph, input logic is_rx);
		int pct;
		case (ph)
			2'd0:    pct = is_rx ? 52 : 37;
			2'd1:    pct = is_rx ? 37 : 52;
			default: pct = 0;
		endcase
		return pct;
	endfunction

	// Advances the shadow parser by one byte; a marked byte yields the buffer's result.
	task automatic parse_byte(input logic [7:0] b, input logic is_last, output logic got,
			output bitrate_res_t r);
		logic [63:0] h;
		logic [63:0] num;
		logic [63:0] den;
		int unsigned hz;
		got = 1'b0;
		r = '0;
		case (fr_phase)
			dhb_pkg::PH_HUNT: begin
				if (hunt_win == dhb_pkg::SYNC_BE_HEAD && b == dhb_pkg::SYNC_BE_TAIL) begin
					fr_phase = dhb_pkg::PH_COLLECT;
					fr_swap = 1'b0;
					hdr_cnt = '0;
				end else if (hunt_win == dhb_pkg::SYNC_SW_HEAD &&
						b == dhb_pkg::SYNC_SW_TAIL) begin
					fr_phase = dhb_pkg::PH_COLLECT;
					fr_swap = 1'b1;
					hdr_cnt = '0;
				end else begin
					hunt_win = {hunt_win[15:0], b};
				end
			end
			dhb_pkg::PH_COLLECT: begin
				hdr_sr = {hdr_sr[55:0], b};
				hdr_cnt = hdr_cnt + 4'd1;
				if (hdr_cnt >= dhb_pkg::HDR_BYTES)
					fr_phase = dhb_pkg::PH_DONE;
			end
			default: ;
		endcase
		if (is_last) begin
			got = 1'b1;
			if (fr_phase == dhb_pkg::PH_HUNT) begin
				r.st = dhb_pkg::ST_NO_SYNC;
			end else begin
				r.sw = fr_swap;
				if (fr_phase != dhb_pkg::PH_DONE) begin
					r.st = dhb_pkg::ST_SHORT;
				end else begin
					h = fr_swap ? swap_byte_pairs(hdr_sr) : hdr_sr;
					hz = sfreq_hz(h[29:26]);
					if (hz == 0) begin
						r.st = dhb_pkg::ST_BAD_RATE;
					end else begin
						num = (64'(h[49:36]) + 64'd1) * 64'd2048 * 64'(hz);
						den = (64'(h[56:50]) + 64'd1) * 64'd32;
						r.st = dhb_pkg::ST_OK;
						r.q8 = dhb_pkg::Q8_W'(num / den);
					end
				end
			end
			hunt_win = '0;
			fr_phase = dhb_pkg::PH_HUNT;
			fr_swap = 1'b0;
			hdr_cnt = '0;
			hdr_sr = '0;
		end
	endtask

	// The idling phase follows the byte count; the first byte of a new phase waits for a drain.
	task automatic add_byte(input logic [7:0] b, input logic is_last);
		byte_item_t it;
		logic [1:0] ph;
		ph = (n_queued < 350) ? 2'd0 : (n_queued < 700) ? 2'd1 : 2'd2;
		it.data = b;
		it.is_last = is_last;
		it.phase = ph;
		it.hold = (ph != fill_phase);
		fill_phase = ph;
		item_q.push_back(it);
		n_queued++;
	endtask

	task automatic add_frame(input int pre_len, input int sync_len, input logic sw,
			input logic [63:0] h, input int hdr_len, input int tail_len);
		logic [7:0] bq[$];
		logic [31:0] sync_word;
		logic [63:0] hs;
		sync_word = sw ? {dhb_pkg::SYNC_SW_HEAD, dhb_pkg::SYNC_SW_TAIL}
			: {dhb_pkg::SYNC_BE_HEAD, dhb_pkg::SYNC_BE_TAIL};
		hs = sw ? swap_byte_pairs(h) : h;
		for (int k = 0; k < pre_len; k++)
			bq.push_back(8'($urandom_range(255)));
		for (int k = 0; k < sync_len; k++)
			bq.push_back(sync_word[31-8*k -: 8]);
		if (sync_len == 4) begin
			for (int k = 0; k < hdr_len; k++)
				bq.push_back(hs[63-8*k -: 8]);
		end
		for (int k = 0; k < tail_len; k++)
			bq.push_back(8'($urandom_range(255)));
		if (bq.size() == 0)
			bq.push_back(8'($urandom_range(255)));
		foreach (bq[k])
			add_byte(bq[k], k == bq.size() - 1);
	endtask

	function automatic logic [63:0] make_header(input logic [6:0] nb, input logic [13:0] fs,
			input logic [3:0] si);
		logic [63:0] h;
		h = {$urandom, $urandom};
		h[56:50] = nb;
		h[49:36] = fs;
		h[29:26] = si;
		return h;
	endfunction

	task automatic fill_stimulus();
		int kind;
		logic [6:0] nb;
		logic [13:0] fs;
		logic [3:0] si;
		// Directed buffers first.
		add_frame(1, 0, 1'b0, '0, 0, 0);
		add_frame(0, 3, 1'b0, '0, 0, 0);
		add_frame(0, 4, 1'b0, make_header(7'd0, 14'h3FFF, 4'd15), 8, 0);
		add_frame(2, 4, 1'b0, make_header(7'd127, 14'd0, 4'd6), 8, 0);
		add_frame(0, 4, 1'b1, make_header(7'd15, 14'd1000, 4'd13), 8, 3);
		add_frame(0, 4, 1'b1, make_header(7'd127, 14'h3FFF, 4'd1), 8, 0);
		add_frame(3, 4, 1'b0, '0, 0, 0);
		add_frame(0, 4, 1'b1, make_header(7'd31, 14'd2012, 4'd8), 7, 0);
		add_frame(0, 4, 1'b0, make_header(7'd15, 14'd500, 4'd0), 8, 0);
		add_frame(1, 4, 1'b1, make_header(7'd15, 14'd500, 4'd9), 8, 2);
		add_frame(0, 4, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8, 0);
		add_frame(0, 4, 1'b1, 64'h0000_0000_0000_0000, 8, 0);
		// A false start of the sync right before the real one.
		add_byte(8'h7F, 1'b0);
		add_byte(8'hFE, 1'b0);
		add_frame(0, 4, 1'b0, make_header(7'd7, 14'd383, 4'd14), 8, 1);

		while (n_queued < 1050) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				case ($urandom_range(9))
					0:       nb = 7'd0;
					1:       nb = 7'd127;
					default: nb = 7'($urandom_range(127));
				endcase
				case ($urandom_range(9))
					0:       fs = 14'd0;
					1:       fs = 14'h3FFF;
					default: fs = 14'($urandom_range(16383));
				endcase
				if ($urandom_range(3) == 0) begin
					si = 4'($urandom_range(15));
				end else begin
					do si = 4'($urandom_range(15)); while (sfreq_hz(si) == 0);
				end
				add_frame($urandom_range(5), 4, 1'($urandom_range(1)),
					make_header(nb, fs, si), 8, $urandom_range(4));
			end else if (kind < 80) begin
				add_frame($urandom_range(3), 4, 1'($urandom_range(1)),
					make_header(7'($urandom_range(127)), 14'($urandom_range(16383)),
					4'($urandom_range(15))), $urandom_range(7), 0);
			end else if (kind < 88) begin
				add_frame($urandom_range(6), $urandom_range(3), 1'($urandom_range(1)), '0, 0,
					$urandom_range(4));
			end else begin
				add_frame($urandom_range(1, 12), 0, 1'b0, '0, 0, 0);
			end
		end
	endtask

	// Sender: a new transaction is offered once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n && (!push || in_fire)) begin
			if (item_q.size() == 0) begin
				push <= 1'b0;
			end else if (item_q[0].hold && result_q.size() != 0) begin
				push <= 1'b0;
			end else if ($urandom_range(99) < idle_pct(item_q[0].phase, 1'b0)) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				data_byte <= item_q[0].data;
				last_byte <= item_q[0].is_last;
				cur_phase <= item_q[0].phase;
				void'(item_q.pop_front());
			end
		end
	end

	// Receiver.
	always @(negedge clk) begin
		if (arst_n)
			pop <= ($urandom_range(99) >= idle_pct(cur_phase, 1'b1));
	end

	always @(posedge clk) begin : monitor
		logic got;
		logic out_fire;
		bitrate_res_t r;
		bitrate_res_t want;
		if (arst_n) begin
			in_fire = push && !full;
			out_fire = pop && !empty;
			if (out_fire) begin
				if (result_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected result: status %0d bitrate_q8 %0d swapped %0b",
							status, bitrate_q8, swapped_order);
				end else begin
					want = result_q.pop_front();
					if (status !== want.st || bitrate_q8 !== want.q8 ||
							swapped_order !== want.sw) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("mismatch: status %0d/%0d bitrate_q8 %0d/%0d swapped %0b/%0b",
								want.st, status, want.q8, bitrate_q8, want.sw, swapped_order);
					end
				end
			end
			if (in_fire) begin
				parse_byte(data_byte, last_byte, got, r);
				if (got)
					result_q.push_back(r);
			end
			if (in_fire || out_fire)
				idle_cyc = 0;
			else
				idle_cyc++;
			if (idle_cyc >= WATCHDOG_LIMIT) begin
				$display("FAIL dts_core_header_bitrate");
				$finish;
			end
		end
	end

	initial begin
		fill_stimulus();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (item_q.size() != 0 || push)
			@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
		// Anything that still shows up now is a result without a transaction behind it.
		repeat (64) @(posedge clk);
		fail_cnt += result_q.size();
		if (fail_cnt == 0)
			$display("PASS dts_core_header_bitrate");
		else
			$display("FAIL dts_core_header_bitrate");
		$finish;
	end

endmodule
